FILE: rtl/indexed_insert_delete_list_assert.svh
// Assertion macros for the indexed insert/delete list.
// Needs clk and arst_n in the scope of the module that includes it.
`ifndef INDEXED_INSERT_DELETE_LIST_ASSERT_SVH
`define INDEXED_INSERT_DELETE_LIST_ASSERT_SVH

// same-cycle implication, held off during reset
`define IIDL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, held off during reset
`define IIDL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/iidl_pkg.sv
// Shared constants, codes and the cell control word for the list.
// No dependencies.
`timescale 1ns / 1ps

package iidl_pkg;

	localparam int CAPACITY  = 16;
	localparam int ELEM_W    = 32;
	localparam int MODE_W    = 3;
	localparam int POS_W     = 5;
	localparam int VAL_W     = 32;
	localparam int RDV_W     = 32;
	localparam int STAT_W    = 2;
	localparam int OUT_CNT_W = 5;
	localparam int CNT_W     = $clog2(CAPACITY + 1);
	localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CMP_W     = (POS_W > CNT_W) ? POS_W : CNT_W;
	localparam int S_TDATA_W = ((POS_W + VAL_W + 7) / 8) * 8;
	localparam int M_TDATA_W = ((RDV_W + OUT_CNT_W + 7) / 8) * 8;

	typedef enum logic [MODE_W-1:0] {
		MODE_INSERT     = 3'd0,
		MODE_PUSH_BACK  = 3'd1,
		MODE_READ       = 3'd2,
		MODE_READ_FRONT = 3'd3,
		MODE_READ_BACK  = 3'd4,
		MODE_DELETE     = 3'd5,
		MODE_POP_FRONT  = 3'd6,
		MODE_POP_BACK   = 3'd7
	} mode_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_EMPTY = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	// broadcast to every cell; ins/del only set on an accepted word
	typedef struct packed {
		logic              ins;
		logic              del;
		logic [IDX_W-1:0]  idx;
		logic [ELEM_W-1:0] value;
	} cell_ctl_t;

endpackage

FILE: rtl/iidl_cell.sv
// One storage cell of the list chain: holds a single element.
// Depends on iidl_pkg.
`timescale 1ns / 1ps

module iidl_cell (
	input  logic                              clk,
	input  logic [iidl_pkg::IDX_W-1:0]        cell_idx,
	input  iidl_pkg::cell_ctl_t               ctl,
	input  logic [iidl_pkg::ELEM_W-1:0]       left_data,
	input  logic [iidl_pkg::ELEM_W-1:0]       right_data,
	output logic [iidl_pkg::ELEM_W-1:0]       data
);
	import iidl_pkg::*;

	logic [ELEM_W-1:0] data_q;

	// insert: cells above the slot take the lower neighbour, the slot takes the new value
	// delete: the slot and everything above take the upper neighbour
	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (cell_idx > ctl.idx) begin
				data_q <= left_data;
			end else if (cell_idx == ctl.idx) begin
				data_q <= ctl.value;
			end
		end else if (ctl.del && (cell_idx >= ctl.idx)) begin
			data_q <= right_data;
		end
	end

	assign data = data_q;

endmodule

FILE: rtl/iidl_ctrl.sv
// Request decode, range/empty/full checks and the element count register.
// Depends on iidl_pkg.
`timescale 1ns / 1ps

module iidl_ctrl (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              fire,
	input  iidl_pkg::mode_t                   mode,
	input  logic [iidl_pkg::POS_W-1:0]        position,
	input  logic [iidl_pkg::VAL_W-1:0]        element_value,
	output iidl_pkg::cell_ctl_t               ctl,
	output logic                              rd_en,
	output iidl_pkg::status_t                 status,
	output logic [iidl_pkg::CNT_W-1:0]        cnt_next,
	output logic [iidl_pkg::CNT_W-1:0]        cnt
);
	import iidl_pkg::*;

	logic [CNT_W-1:0] cnt_q;
	logic [CMP_W-1:0] pos_c;
	logic [CMP_W-1:0] cnt_c;
	logic [CMP_W-1:0] cap_c;
	logic [CMP_W-1:0] last_c;
	logic [CMP_W-1:0] tgt;
	logic             ins_ok;
	logic             del_ok;
	logic             is_empty;

	assign pos_c    = CMP_W'(position);
	assign cnt_c    = CMP_W'(cnt_q);
	assign cap_c    = CMP_W'(CAPACITY);
	assign last_c   = cnt_c - CMP_W'(1);
	assign is_empty = (cnt_q == '0);

	always_comb begin
		ins_ok = 1'b0;
		del_ok = 1'b0;
		rd_en  = 1'b0;
		tgt    = '0;
		status = ST_OK;
		case (mode)
			MODE_INSERT: begin
				tgt = pos_c;
				if (pos_c > cnt_c) begin
					status = ST_RANGE;
				end else if (cnt_c == cap_c) begin
					status = ST_FULL;
				end else begin
					ins_ok = 1'b1;
				end
			end
			MODE_PUSH_BACK: begin
				tgt = cnt_c;
				if (cnt_c == cap_c) begin
					status = ST_FULL;
				end else begin
					ins_ok = 1'b1;
				end
			end
			MODE_READ: begin
				tgt = pos_c;
				if (pos_c >= cnt_c) begin
					status = ST_RANGE;
				end else begin
					rd_en = 1'b1;
				end
			end
			MODE_READ_FRONT: begin
				if (is_empty) begin
					status = ST_RANGE;
				end else begin
					rd_en = 1'b1;
				end
			end
			MODE_READ_BACK: begin
				tgt = last_c;
				if (is_empty) begin
					status = ST_RANGE;
				end else begin
					rd_en = 1'b1;
				end
			end
			MODE_DELETE: begin
				tgt = pos_c;
				if (is_empty) begin
					status = ST_EMPTY;
				end else if (pos_c >= cnt_c) begin
					status = ST_RANGE;
				end else begin
					del_ok = 1'b1;
				end
			end
			MODE_POP_FRONT: begin
				if (is_empty) begin
					status = ST_EMPTY;
				end else begin
					del_ok = 1'b1;
				end
			end
			MODE_POP_BACK: begin
				tgt = last_c;
				if (is_empty) begin
					status = ST_EMPTY;
				end else begin
					del_ok = 1'b1;
				end
			end
			default: begin
				status = ST_OK;
			end
		endcase
	end

	// tgt is below CAPACITY whenever it is used, so the truncation is safe
	assign ctl.ins   = fire & ins_ok;
	assign ctl.del   = fire & del_ok;
	assign ctl.idx   = IDX_W'(tgt);
	assign ctl.value = ELEM_W'(element_value);

	always_comb begin
		if (ins_ok) begin
			cnt_next = cnt_q + CNT_W'(1);
		end else if (del_ok) begin
			cnt_next = cnt_q - CNT_W'(1);
		end else begin
			cnt_next = cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (fire) begin
			cnt_q <= cnt_next;
		end
	end

	assign cnt = cnt_q;

endmodule

FILE: rtl/indexed_insert_delete_list.sv
// Indexed insert/delete list: CAPACITY register cells in a chain, shifted in parallel.
// Result: the result word is registered and appears on the master side in the cycle after the request is taken.
// Throughput: one request per cycle; the single output register sets the pace under stall.
// Reset (arst_n low): count cleared, output empty; cell contents are left as they were.
// Depends on iidl_pkg, iidl_ctrl, iidl_cell and indexed_insert_delete_list_assert.svh.
`timescale 1ns / 1ps

module indexed_insert_delete_list (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// position [4:0], element_value [36:5], zero fill above
	input  logic [iidl_pkg::S_TDATA_W-1:0]       s_tdata,
	// mode [2:0]
	input  logic [iidl_pkg::MODE_W-1:0]          s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// read_value [31:0], element_count [36:32], zero fill above
	output logic [iidl_pkg::M_TDATA_W-1:0]       m_tdata,
	// status [1:0]
	output logic [iidl_pkg::STAT_W-1:0]          m_tuser
);
	import iidl_pkg::*;
	`include "indexed_insert_delete_list_assert.svh"

	logic                 fire;
	cell_ctl_t            ctl;
	logic                 rd_en;
	status_t              status;
	logic [CNT_W-1:0]     cnt_next;
	logic [CNT_W-1:0]     cnt;
	logic [ELEM_W-1:0]    cell_data [CAPACITY];

	// output register
	logic                 m_tvalid_q;
	logic [RDV_W-1:0]     rdv_q;
	status_t              status_q;
	logic [OUT_CNT_W-1:0] ocnt_q;

	// a new word may enter whenever the output slot is free or is being drained
	assign s_tready = !m_tvalid_q || m_tready;
	assign fire     = s_tvalid && s_tready;

	iidl_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (fire),
		.mode          (mode_t'(s_tuser)),
		.position      (s_tdata[POS_W-1:0]),
		.element_value (s_tdata[POS_W+VAL_W-1:POS_W]),
		.ctl           (ctl),
		.rd_en         (rd_en),
		.status        (status),
		.cnt_next      (cnt_next),
		.cnt           (cnt)
	);

	// Cell chain. Cell 0 never takes its lower neighbour and the top cell's
	// upper neighbour is beyond the list, so both ends are tied to harmless values.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [ELEM_W-1:0] left_d;
		logic [ELEM_W-1:0] right_d;

		if (i == 0) begin : g_lo
			assign left_d = ctl.value;
		end else begin : g_lo
			assign left_d = cell_data[i-1];
		end

		if (i == CAPACITY - 1) begin : g_hi
			assign right_d = cell_data[i];
		end else begin : g_hi
			assign right_d = cell_data[i+1];
		end

		iidl_cell u_cell (
			.clk        (clk),
			.cell_idx   (IDX_W'(i)),
			.ctl        (ctl),
			.left_data  (left_d),
			.right_data (right_d),
			.data       (cell_data[i])
		);
	end

	// Result register: read value sampled before the chain moves, count after the request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (fire) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rdv_q    <= rd_en ? RDV_W'(cell_data[ctl.idx]) : '0;
			status_q <= status;
			ocnt_q   <= OUT_CNT_W'(cnt_next);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = M_TDATA_W'({ocnt_q, rdv_q});

	// checks
	`IIDL_ASSERT_NOW(a_cnt_bound, 1'b1, cnt <= CNT_W'(CAPACITY), "count above capacity")
	`IIDL_ASSERT_NEXT(a_fire_gives_word, fire, m_tvalid_q, "accepted word gave no result")
	`IIDL_ASSERT_NEXT(a_cnt_idle, !fire, $stable(cnt), "count moved without a request")
	`IIDL_ASSERT_NOW(a_full_at_cap, m_tvalid_q && (status_q == ST_FULL), ocnt_q == OUT_CNT_W'(CAPACITY), "full reported below capacity")

endmodule
